### design/utra_pkg.sv
// Shared types, constants and helpers for the radix-to-ASCII converter.
`default_nettype none

package utra_pkg;

    // Radix limits and division step size.
    localparam logic [4:0] RADIX_MIN = 5'd2;
    localparam logic [4:0] RADIX_MAX = 5'd16;
    localparam int STEP_BITS = 8;

    // ASCII anchors for digit mapping.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_NONE    = 8'h00;

    // Input transaction payload.
    typedef struct packed {
        logic [63:0] number;
        logic [4:0]  radix;
        logic        upper_case;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [7:0] digit_char;
        logic       last;
        logic       error;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_start;
        logic rd;
        logic out_load;
        logic err_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic radix_ok;
        logic div_last;
        logic quot_zero;
        logic out_free;
        logic rlast;
    } status_t;

    // Maps a digit value to its ASCII code in the selected letter case.
    function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10)
        begin
            base = CHAR_ZERO;
        end
        else if (upper)
        begin
            base = CHAR_UPPER_A - 8'd10;
        end
        else
        begin
            base = CHAR_LOWER_A - 8'd10;
        end
        return base + {4'b0000, d};
    endfunction

endpackage

`default_nettype wire

### design/utra_ctrl.sv
// Sequencing state machine for the radix-to-ASCII converter.
`default_nettype none

module utra_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire utra_pkg::status_t status,
    output utra_pkg::cmd_t         cmd
);
    import utra_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.radix_ok)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_ERR;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last && status.quot_zero)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.emit_start = 1'b1;
                state_next     = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.rlast)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd = 1'b1;
                    end
                end
            end
            S_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.err_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/utra_datapath.sv
// Digit divider, digit store and output register of the radix-to-ASCII converter.
`default_nettype none

module utra_datapath #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire utra_pkg::in_item_t  in_data,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output utra_pkg::out_item_t      out_data,
    input  wire utra_pkg::cmd_t      cmd,
    output utra_pkg::status_t        status
);
    import utra_pkg::*;

    localparam int DIV_CYCLES = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W      = DIV_CYCLES * STEP_BITS;
    localparam int SW         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int CW         = $clog2(VALUE_WIDTH + 1);
    localparam int AW         = $clog2(MAX_DIGITS);
    localparam int LW         = (CW > AW + 1) ? CW : AW + 1;

    logic [PAD_W-1:0]     work_reg;
    logic [PAD_W-1:0]     work_next;
    logic [PAD_W-1:0]     work_step;
    logic [3:0]           rem_reg;
    logic [3:0]           rem_next;
    logic [3:0]           rem_step;
    logic [SW-1:0]        step_reg;
    logic [SW-1:0]        step_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [4:0]           radix_reg;
    logic                 upper_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [AW-1:0]        rd_idx_next;
    logic [3:0]           rdata_reg;
    logic                 rlast_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_data_reg;
    out_item_t            out_data_next;
    logic [STEP_BITS-1:0] qbits;
    logic [LW-1:0]        count_lw;
    logic [LW-1:0]        digit_lim;
    logic                 wr_en;
    logic [3:0]           digit_mem [MAX_DIGITS];

    // One division step: shift eight dividend bits through the remainder.
    always_comb
    begin
        logic [3:0] r;
        logic [4:0] t;
        r = rem_reg;
        qbits = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t = {r, work_reg[PAD_W-1-i]};
            if (t >= radix_reg)
            begin
                qbits[STEP_BITS-1-i] = 1'b1;
                r = 4'(t - radix_reg);
            end
            else
            begin
                r = t[3:0];
            end
        end
        rem_step  = r;
        work_step = (work_reg << STEP_BITS) | PAD_W'(qbits);
    end

    // Digit count limits and store write enable.
    assign count_lw  = LW'(count_reg);
    assign digit_lim = (count_lw > LW'(MAX_DIGITS)) ? LW'(MAX_DIGITS) : count_lw;
    assign wr_en     = cmd.div_step && status.div_last && (count_lw < LW'(MAX_DIGITS));

    // Status toward the controller.
    assign status.radix_ok  = (in_data.radix >= RADIX_MIN) && (in_data.radix <= RADIX_MAX);
    assign status.div_last  = (step_reg == SW'(DIV_CYCLES - 1));
    assign status.quot_zero = (work_step == '0);
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.rlast     = rlast_reg;

    // Next values of the division and emission registers.
    always_comb
    begin
        work_next   = work_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.load)
        begin
            work_next  = PAD_W'(in_data.number[VALUE_WIDTH-1:0]);
            rem_next   = '0;
            step_next  = '0;
            count_next = '0;
        end
        else if (cmd.div_step)
        begin
            work_next = work_step;
            if (status.div_last)
            begin
                rem_next   = '0;
                step_next  = '0;
                count_next = count_reg + CW'(1);
            end
            else
            begin
                rem_next  = rem_step;
                step_next = step_reg + SW'(1);
            end
        end
        if (cmd.emit_start)
        begin
            rd_idx_next = AW'(digit_lim - LW'(1));
        end
        else if (cmd.rd)
        begin
            rd_idx_next = rd_idx_reg - AW'(1);
        end
    end

    // Output register next value.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.out_load)
        begin
            out_valid_next           = 1'b1;
            out_data_next.digit_char = digit_ascii(rdata_reg, upper_reg);
            out_data_next.last       = rlast_reg;
            out_data_next.error      = 1'b0;
        end
        else if (cmd.err_load)
        begin
            out_valid_next           = 1'b1;
            out_data_next.digit_char = CHAR_NONE;
            out_data_next.last       = 1'b1;
            out_data_next.error      = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        rd_idx_reg   <= rd_idx_next;
        out_data_reg <= out_data_next;
        if (cmd.load)
        begin
            radix_reg <= in_data.radix;
            upper_reg <= in_data.upper_case;
        end
    end

    // Digit store: written least significant digit first, read back in reverse.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_mem[count_reg[AW-1:0]] <= rem_step;
        end
        if (cmd.rd)
        begin
            rdata_reg <= digit_mem[rd_idx_reg];
            rlast_reg <= (rd_idx_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### design/unsigned_to_radix_ascii.sv
// Top level of the unsigned integer to ASCII digit converter, radix 2 to 16.
//
// Each input transaction carries a number, a radix and a letter-case flag; the
// block returns one output transaction per digit, most significant first, with
// last set on the final one. Only the low VALUE_WIDTH bits of the number are
// used; zero gives the single digit '0', and when more than MAX_DIGITS digits
// are needed only the MAX_DIGITS least significant ones come out. A radix
// outside 2 to 16 gives one transaction with error and last set and a zero
// character. Digits come from a shared restoring divider that handles eight
// dividend bits per cycle and finds each digit in one full pass over the
// dividend. All digits are found before the first one comes out; after that
// they stream out at one per cycle from the digit store while the receiver
// stays ready. The next number is accepted as soon as the last digit sits in
// the output register.
`default_nettype none

module unsigned_to_radix_ascii #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire utra_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output utra_pkg::out_item_t      out_data
);
    import utra_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    utra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Divider, digit store and output register.
    utra_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

    // The output register is never overwritten while it holds an undelivered result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load || cmd.err_load) |-> (!out_valid || out_ready))
        else $error("output register overwritten before its transaction completed");

    // A valid conversion keeps the input side closed on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && status.radix_ok) |=> !in_ready)
        else $error("input accepted again while a conversion was starting");

    // An error result is a single, final result with a zero character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error) |-> (out_data.last && (out_data.digit_char == CHAR_NONE)))
        else $error("malformed error result");

endmodule

`default_nettype wire

### sim/unsigned_to_radix_ascii_checker.sv
// Checker for the radix-to-ASCII converter: watches both channels, predicts digits, compares.
`timescale 1ns / 100ps

module unsigned_to_radix_ascii_checker #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  utra_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  utra_pkg::out_item_t out_data,
    output int                  mismatch_count,
    output int                  pending_digits
);
    import utra_pkg::*;

    localparam logic [63:0] VALUE_MASK =
        (VALUE_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
    localparam int DIGIT_CAP = (MAX_DIGITS > 64) ? 64 : ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);

    // Digits still owed by the block, oldest first.
    out_item_t expected_digits[$];

    // Prints one line per discrepancy and counts it.
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ASCII code of one digit value in the requested letter case.
    function automatic logic [7:0] digit_to_char(input logic [3:0] d, input logic upper);
        if (d < 4'd10)
        begin
            return CHAR_ZERO + {4'd0, d};
        end
        return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'd0, d - 4'd10};
    endfunction

    // Queues the digit string that one accepted number must produce.
    function automatic void predict_digits(input in_item_t item);
        logic [63:0] value;
        logic [63:0] divisor;
        logic [3:0]  reversed [0:63];
        int          count;
        int          emit;
        out_item_t   digit;

        if (item.radix < RADIX_MIN || item.radix > RADIX_MAX)
        begin
            digit.digit_char = CHAR_NONE;
            digit.last       = 1'b1;
            digit.error      = 1'b1;
            expected_digits.push_back(digit);
            return;
        end

        // Repeated division gives the least significant digit first.
        value   = item.number & VALUE_MASK;
        divisor = {59'd0, item.radix};
        count   = 0;
        do
        begin
            reversed[count] = 4'(value % divisor);
            value           = value / divisor;
            count++;
        end
        while (value != 64'd0 && count < 64);

        // Only the lowest DIGIT_CAP digits come out, most significant first.
        emit = (count > DIGIT_CAP) ? DIGIT_CAP : count;
        for (int k = emit; k > 0; k--)
        begin
            digit.digit_char = digit_to_char(reversed[k - 1], item.upper_case);
            digit.last       = (k == 1);
            digit.error      = 1'b0;
            expected_digits.push_back(digit);
        end
    endfunction

    // Compare each output transaction, then record each input transaction.
    always @(posedge clk)
    begin : watch_channels
        out_item_t want;
        if (!rst_n)
        begin
            mismatch_count = 0;
            pending_digits = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    report_mismatch("unexpected digit_char", out_data.digit_char, CHAR_NONE);
                end
                else
                begin
                    want = expected_digits.pop_front();
                    if (out_data.digit_char !== want.digit_char)
                    begin
                        report_mismatch("digit_char", out_data.digit_char, want.digit_char);
                    end
                    if (out_data.last !== want.last)
                    begin
                        report_mismatch("last", {7'd0, out_data.last}, {7'd0, want.last});
                    end
                    if (out_data.error !== want.error)
                    begin
                        report_mismatch("error", {7'd0, out_data.error}, {7'd0, want.error});
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_digits(in_data);
            end
            pending_digits = expected_digits.size();
        end
    end

endmodule

### sim/tb_unsigned_to_radix_ascii.sv
// Testbench top for the radix-to-ASCII converter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_unsigned_to_radix_ascii;
    import utra_pkg::*;

    localparam int VALUE_WIDTH  = 64;
    localparam int MAX_DIGITS   = 64;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 600;
    localparam int CYCLE_LIMIT  = 1500000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        mismatch_count;
    int        pending_digits;
    int        cycle_count = 0;
    int        burst_left;

    unsigned_to_radix_ascii #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    unsigned_to_radix_ascii_checker #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) digit_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .mismatch_count(mismatch_count),
        .pending_digits(pending_digits)
    );

    // Free-running clock, 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: alternates between always ready, coin-flip ready and long stalls.
    initial
    begin : receiver
        int mode;
        int stretch;
        int hold;
        out_ready = 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(20, 200);
            while (stretch > 0)
            begin
                if (mode == 2)
                begin
                    hold = $urandom_range(1, 8);
                    repeat (hold)
                    begin
                        @(negedge clk);
                        out_ready <= 1'b0;
                    end
                    hold = $urandom_range(1, 4);
                    repeat (hold)
                    begin
                        @(negedge clk);
                        out_ready <= 1'b1;
                    end
                    stretch = stretch - 12;
                end
                else
                begin
                    @(negedge clk);
                    out_ready <= (mode == 0) ? 1'b1 : 1'($urandom_range(0, 1));
                    stretch--;
                end
            end
        end
    end

    // Offers one number; bursts of back-to-back transactions with random gaps.
    task automatic send_number(input logic [63:0] number, input logic [4:0] radix,
                               input logic upper);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        in_valid           <= 1'b1;
        in_data.number     <= number;
        in_data.radix      <= radix;
        in_data.upper_case <= upper;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        burst_left--;
    endtask

    // Holds the input idle until every owed digit has come out.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_digits != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Random number whose significant width varies, mostly small.
    function automatic logic [63:0] random_number();
        logic [63:0] full;
        full = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
        begin
            return full;
        end
        return full >> $urandom_range(8, 63);
    endfunction

    // Reset, directed cases, random traffic, then the verdict.
    initial
    begin : stimulus
        logic [4:0] radix;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        burst_left = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Zero in several radixes.
        send_number(64'd0, 5'd2, 1'b0);
        send_number(64'd0, 5'd10, 1'b1);
        send_number(64'd0, 5'd16, 1'b0);
        // Largest value: 64 binary digits is the longest string.
        send_number({64{1'b1}}, 5'd2, 1'b0);
        send_number({64{1'b1}}, 5'd3, 1'b0);
        send_number({64{1'b1}}, 5'd10, 1'b0);
        send_number({64{1'b1}}, 5'd16, 1'b0);
        send_number({64{1'b1}}, 5'd16, 1'b1);
        // Every letter in both cases.
        send_number(64'hFEDC_BA98_7654_3210, 5'd16, 1'b0);
        send_number(64'hFEDC_BA98_7654_3210, 5'd16, 1'b1);
        send_number(64'd1, 5'd2, 1'b0);
        send_number(64'h8000_0000_0000_0000, 5'd2, 1'b0);
        send_number(64'd9, 5'd10, 1'b0);
        send_number(64'd10, 5'd11, 1'b1);
        send_number(64'd10_000_000_000_000_000_000, 5'd10, 1'b0);
        send_number(64'd8, 5'd8, 1'b0);
        send_number(64'd16, 5'd16, 1'b1);
        send_number(64'd224, 5'd15, 1'b1);
        send_number(64'd342, 5'd7, 1'b0);
        // Radixes outside the legal range.
        send_number(64'd12345, 5'd0, 1'b0);
        send_number(64'd12345, 5'd1, 1'b1);
        send_number(64'd12345, 5'd17, 1'b0);
        send_number({64{1'b1}}, 5'd31, 1'b1);

        wait_for_drain();

        // Mostly legal radixes with random values, some arbitrary radix fields.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                radix = 5'($urandom_range(0, 31));
            end
            else
            begin
                radix = 5'($urandom_range(2, 16));
            end
            send_number(random_number(), radix, 1'($urandom_range(0, 1)));
            if (n % 60 == 59)
            begin
                wait_for_drain();
            end
        end

        // Let the last digits out, then give stray output time to show up.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
